>>> hdl/dq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
// No dependencies; imported by double_ended_queue.

package dq_pkg;

  localparam int VAL_W = 32;   // width of item_value and popped_value
  localparam int OCC_W = 5;    // width of the occupancy field
  localparam int CMD_W = 2;
  localparam int STS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

>>> hdl/dq_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // hold read data when no read is issued
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/double_ended_queue.sv
`timescale 1ns / 1ps
// A result word passes through the RAM read stage and then the output register.
// Throughput: one command per cycle while the output is not stalled; a push that is not
// refused writes the ring RAM, a pop that is not refused reads it, and no command does both.
// Reset (synchronous, rst_n low): front/rear pointers, count and valid flags clear;
// the ring RAM is not cleared and needs no clearing pass.

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // slave side
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] item_value
  input  logic [1:0]   in_tuser,   // [1:0] command
  // master side
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // [31:0] popped_value, [36:32] occupancy, [39:37] zero
  output logic [1:0]   out_tuser   // [1:0] status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  // queue state
  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] rear_r, rear_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // RAM read stage and output register
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_pop_r;
  status_t           s1_status_r;
  logic [OCC_W-1:0]  s1_occ_r;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_val_r;
  status_t           out_status_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic              acc, s1_adv;
  cmd_t              cmd;
  logic              is_push, full, empty, push_ok, pop_ok;
  status_t           status;
  logic [AW-1:0]     front_prev, front_next, rear_prev, rear_next;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign acc       = in_tvalid && in_tready;

  assign cmd     = cmd_t'(in_tuser);
  assign is_push = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_REAR);
  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign push_ok = is_push && !full;
  assign pop_ok  = !is_push && !empty;

  assign front_prev = (front_r == '0) ? LAST_IDX : front_r - AW'(1);
  assign front_next = (front_r == LAST_IDX) ? '0 : front_r + AW'(1);
  assign rear_prev  = (rear_r == '0) ? LAST_IDX : rear_r - AW'(1);
  assign rear_next  = (rear_r == LAST_IDX) ? '0 : rear_r + AW'(1);

  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    count_nxt = count_r;
    status    = ST_DONE;
    if (is_push && full) begin
      status = ST_FULL;
    end else if (!is_push && empty) begin
      status = ST_EMPTY;
    end
    if (acc) begin
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (push_ok) begin
            front_nxt = front_prev;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_PUSH_REAR: begin
          if (push_ok) begin
            rear_nxt  = rear_next;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (pop_ok) begin
            front_nxt = front_next;
            count_nxt = count_r - CW'(1);
          end
        end
        CMD_POP_REAR: begin
          if (pop_ok) begin
            rear_nxt  = rear_prev;
            count_nxt = count_r - CW'(1);
          end
        end
        default: begin
          front_nxt = front_r;
        end
      endcase
    end
  end

  // a push writes and a pop reads; one command never does both
  assign ram_we    = acc && push_ok;
  assign ram_waddr = (cmd == CMD_PUSH_FRONT) ? front_prev : rear_r;
  assign ram_wdata = WORD_BITS'(in_tdata);
  assign ram_re    = acc && pop_ok;
  assign ram_raddr = (cmd == CMD_POP_FRONT) ? front_r : rear_prev;

  dq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      rear_r      <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      count_r     <= count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pop_r    <= pop_ok;
      s1_status_r <= status;
      s1_occ_r    <= OCC_W'(count_nxt);
    end
    if (s1_adv) begin
      out_val_r    <= s1_pop_r ? VAL_W'(ram_rdata) : '0;
      out_status_r <= s1_status_r;
      out_occ_r    <= s1_occ_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_occ_r, out_val_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("count exceeds capacity");

  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FULL_CNT) |-> (front_r == rear_r))
    else $error("pointers disagree with empty/full count");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_push && full) |=> $stable(count_r) && $stable(front_r) && $stable(rear_r))
    else $error("refused push changed queue state");

  a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("ring RAM read and written in the same cycle");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EMPTY) |-> (out_occ_r == '0 && out_val_r == '0))
    else $error("empty refusal with nonzero payload");
`endif

endmodule
